FILE: hw/rtl/ezcd_pkg.sv
// shared types and constants of the extremum and zero crossing detector
package ezcd_pkg;

  // fixed widths of the result fields
  localparam int unsigned POS_W = 16;
  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // event queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  // result kinds
  typedef enum logic [1:0] {
    KIND_MAX  = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_ZERO = 2'd2,
    KIND_SUM  = 2'd3
  } kind_e;

  // direction of the first difference
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DN   = 2'd2,
    DIR_FLAT = 2'd3
  } dir_e;

  // events caused by one sample, in emission order
  typedef struct packed {
    logic             zc_vld;
    logic [POS_W-1:0] zc_pos;
    logic             ext_vld;
    logic             ext_min;
    logic [POS_W-1:0] ext_pos;
    logic             ez_vld;
    logic [POS_W-1:0] ez_pos;
    logic             last;
    logic             ovf;
  } ezcd_rec_t;

endpackage

FILE: hw/rtl/ezcd_front.sv
// front end: accepts samples and classifies them into event records
module ezcd_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output ezcd_pkg::ezcd_rec_t           rec_o
);
  import ezcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LEN + 1);

  logic signed [SAMPLE_BITS-1:0] prev_q;
  dir_e                          pdir_q, entry_q, dir;
  logic [IDX_W-1:0]              idx_q, run_start_q, idx_m1, mid;
  logic [IDX_W:0]                mid_sum;
  logic                          in_run_q, ovf_q;
  logic                          accept, has_prev, len_full;
  logic                          prev_neg, prev_pos, x_neg, x_pos, x_zero;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // sample and index conditions
  assign has_prev = idx_q != '0;
  assign len_full = idx_q >= IDX_W'(MAX_LEN);
  assign idx_m1   = idx_q - IDX_W'(1);
  assign mid_sum  = {1'b0, run_start_q} + {1'b0, idx_q};
  assign mid      = mid_sum[IDX_W:1];
  assign prev_neg = prev_q[SAMPLE_BITS-1];
  assign prev_pos = !prev_q[SAMPLE_BITS-1] && (prev_q != '0);
  assign x_neg    = sample_i[SAMPLE_BITS-1];
  assign x_zero   = sample_i == '0;
  assign x_pos    = !x_neg && !x_zero;

  // direction of the new difference
  always_comb begin
    if (sample_i > prev_q) begin
      dir = DIR_UP;
    end else if (sample_i < prev_q) begin
      dir = DIR_DN;
    end else begin
      dir = DIR_FLAT;
    end
  end

  // event classification
  always_comb begin
    rec_o         = '0;
    rec_o.zc_pos  = POS_W'(idx_m1);
    rec_o.ez_pos  = POS_W'(idx_q);
    rec_o.ext_pos = POS_W'(idx_m1);
    rec_o.last    = last_i;
    rec_o.ovf     = ovf_q || len_full;
    if (!len_full) begin
      rec_o.ez_vld = x_zero;
      if (has_prev) begin
        rec_o.zc_vld = (prev_neg && x_pos) || (prev_pos && x_neg);
        if (dir != DIR_FLAT) begin
          if (pdir_q == DIR_UP && dir == DIR_DN) begin
            rec_o.ext_vld = 1'b1;
          end else if (pdir_q == DIR_DN && dir == DIR_UP) begin
            rec_o.ext_vld = 1'b1;
            rec_o.ext_min = 1'b1;
          end else if (in_run_q) begin
            rec_o.ext_pos = POS_W'(mid);
            if (entry_q == DIR_UP && dir == DIR_DN) begin
              rec_o.ext_vld = 1'b1;
            end else if (entry_q == DIR_DN && dir == DIR_UP) begin
              rec_o.ext_vld = 1'b1;
              rec_o.ext_min = 1'b1;
            end
          end
        end
      end
    end
  end

  // tracking state, cleared after the last sample of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      pdir_q      <= DIR_NONE;
      entry_q     <= DIR_NONE;
      idx_q       <= '0;
      run_start_q <= '0;
      in_run_q    <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        prev_q      <= '0;
        pdir_q      <= DIR_NONE;
        entry_q     <= DIR_NONE;
        idx_q       <= '0;
        run_start_q <= '0;
        in_run_q    <= 1'b0;
        ovf_q       <= 1'b0;
      end else if (len_full) begin
        ovf_q <= 1'b1;
      end else begin
        if (has_prev) begin
          if (dir != DIR_FLAT) begin
            in_run_q <= 1'b0;
          end else if (!in_run_q) begin
            in_run_q    <= 1'b1;
            run_start_q <= idx_m1;
            entry_q     <= (pdir_q == DIR_FLAT) ? DIR_NONE : pdir_q;
          end
          pdir_q <= dir;
        end
        prev_q <= sample_i;
        idx_q  <= idx_q + IDX_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/ezcd_fifo.sv
// short queue of event records between front and back
module ezcd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ezcd_pkg::ezcd_rec_t rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_vld_o,
  output ezcd_pkg::ezcd_rec_t head_o
);
  import ezcd_pkg::*;

  ezcd_rec_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o     = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign head_vld_o = cnt_q != '0;
  assign head_o     = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_vld_o)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_o |-> (FIFO_PTR_W'(wr_q - rd_q) == cnt_q[FIFO_PTR_W-1:0]))
    else $error("pointers disagree with count");
`endif

endmodule

FILE: hw/rtl/ezcd_back.sv
// back end: emits events of each record in order, keeps counts, builds the summary
module ezcd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_vld_i,
  input  ezcd_pkg::ezcd_rec_t             head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [ezcd_pkg::POS_W-1:0]      position_o,
  output logic [ezcd_pkg::CNT_W-1:0]      count_max_o,
  output logic [ezcd_pkg::CNT_W-1:0]      count_min_o,
  output logic [ezcd_pkg::CNT_W-1:0]      count_zero_o,
  output logic                            imf_ok_o,
  output logic                            overflow_o,
  output logic                            final_res_o
);
  import ezcd_pkg::*;

  logic [3:0]       req, pend, sel, rest, served_q;
  logic             out_en, load;
  logic [CNT_W-1:0] cmax_q, cmin_q, czero_q;
  logic [CNT_W:0]   ext_sum, zero_ext;
  logic             imf_ok;
  logic             vld_q, imf_q, ovf_q, fin_q;
  logic [1:0]       kind_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] omax_q, omin_q, ozero_q;
  logic [1:0]       kind_d;
  logic [POS_W-1:0] pos_d;

  // pending results of the head record, lowest bit first
  assign req    = {head_i.last, head_i.ez_vld, head_i.ext_vld, head_i.zc_vld}
                  & {4{head_vld_i}};
  assign pend   = req & ~served_q;
  assign sel    = pend & (~pend + 4'd1);
  assign rest   = pend & ~sel;
  assign out_en = !vld_q || out_ready_i;
  assign load   = out_en && (pend != '0);
  assign pop_o  = head_vld_i && ((pend == '0) || (load && (rest == '0)));

  // imf check on the current counts
  assign ext_sum  = {1'b0, cmax_q} + {1'b0, cmin_q};
  assign zero_ext = {1'b0, czero_q};
  assign imf_ok   = (ext_sum >= zero_ext) ? ((ext_sum - zero_ext) <= (CNT_W+1)'(1))
                                          : ((zero_ext - ext_sum) <= (CNT_W+1)'(1));

  // kind and position of the selected result
  always_comb begin
    kind_d = KIND_SUM;
    pos_d  = '0;
    if (sel[0]) begin
      kind_d = KIND_ZERO;
      pos_d  = head_i.zc_pos;
    end else if (sel[1]) begin
      kind_d = head_i.ext_min ? KIND_MIN : KIND_MAX;
      pos_d  = head_i.ext_pos;
    end else if (sel[2]) begin
      kind_d = KIND_ZERO;
      pos_d  = head_i.ez_pos;
    end
  end

  // served mask and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      served_q <= '0;
      cmax_q   <= '0;
      cmin_q   <= '0;
      czero_q  <= '0;
    end else begin
      if (pop_o) begin
        served_q <= '0;
      end else if (load) begin
        served_q <= served_q | sel;
      end
      if (load) begin
        if (sel[3]) begin
          cmax_q  <= '0;
          cmin_q  <= '0;
          czero_q <= '0;
        end else if (sel[1]) begin
          if (head_i.ext_min) begin
            cmin_q <= (cmin_q == CNT_SAT) ? cmin_q : cmin_q + CNT_W'(1);
          end else begin
            cmax_q <= (cmax_q == CNT_SAT) ? cmax_q : cmax_q + CNT_W'(1);
          end
        end else begin
          czero_q <= (czero_q == CNT_SAT) ? czero_q : czero_q + CNT_W'(1);
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (out_en) begin
      vld_q <= load;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      fin_q   <= sel[3];
      omax_q  <= sel[3] ? cmax_q : '0;
      omin_q  <= sel[3] ? cmin_q : '0;
      ozero_q <= sel[3] ? czero_q : '0;
      imf_q   <= sel[3] && imf_ok;
      ovf_q   <= sel[3] && head_i.ovf;
    end
  end

  assign out_valid_o  = vld_q;
  assign kind_o       = kind_q;
  assign position_o   = pos_q;
  assign count_max_o  = omax_q;
  assign count_min_o  = omin_q;
  assign count_zero_o = ozero_q;
  assign imf_ok_o     = imf_q;
  assign overflow_o   = ovf_q;
  assign final_res_o  = fin_q;

`ifndef SYNTHESIS
  a_served_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (served_q & ~req) == '0)
    else $error("served mask holds a result the head does not have");
  a_final_is_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_res_o == (kind_o == KIND_SUM)))
    else $error("summary flag and kind disagree");
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sel[3]) |=> (cmax_q == '0 && cmin_q == '0 && czero_q == '0))
    else $error("counters not cleared after summary");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (served_q == $past(served_q)))
    else $error("record advanced while output stalled");
`endif

endmodule

FILE: hw/rtl/extremum_zero_crossing_detector_top.sv
// top level of the extremum and zero crossing detector
//
// Input channel: one signed sample per item with last marking the final sample
// of a buffer; handshake in_valid_i / in_ready_o. Output channel: one event per
// item (maximum, minimum, zero point) or the end-of-buffer summary with counts,
// imf flag and overflow flag; handshake out_valid_o / out_ready_i.
// The front end classifies a sample in the cycle it is accepted and writes an
// event record into a four-entry queue. The back end turns each record into
// zero to three result items, one per cycle while the receiver takes them,
// through a registered output stage, which a sample's first result reaches
// after the queue. Throughput: one sample per cycle in while the queue is not
// full, one result per cycle out while the receiver takes it; a sample holds
// the back end for each result it causes and also when it causes none, so the
// back end sets the sustained rate and the queue absorbs bursts of busy samples.
// When the receiver stalls, the output item holds, the queue fills and in_ready_o
// drops once it is full. Reset clears all tracking state, counters and the queue;
// the block accepts items as soon as reset is released. After the summary the
// state is cleared and the next item starts a new buffer at position zero.
module extremum_zero_crossing_detector_top #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [ezcd_pkg::POS_W-1:0]    position_o,
  output logic [ezcd_pkg::CNT_W-1:0]    count_max_o,
  output logic [ezcd_pkg::CNT_W-1:0]    count_min_o,
  output logic [ezcd_pkg::CNT_W-1:0]    count_zero_o,
  output logic                          imf_ok_o,
  output logic                          overflow_o,
  output logic                          final_res_o
);
  import ezcd_pkg::*;

  logic      push, full, pop, head_vld;
  ezcd_rec_t rec, head;

  // sample classification
  ezcd_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .fifo_full_i(full),
    .push_o     (push),
    .rec_o      (rec)
  );

  // event record queue
  ezcd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rec_i     (rec),
    .full_o    (full),
    .pop_i     (pop),
    .head_vld_o(head_vld),
    .head_o    (head)
  );

  // result emission
  ezcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .position_o  (position_o),
    .count_max_o (count_max_o),
    .count_min_o (count_min_o),
    .count_zero_o(count_zero_o),
    .imf_ok_o    (imf_ok_o),
    .overflow_o  (overflow_o),
    .final_res_o (final_res_o)
  );

endmodule

FILE: tb/sv/tb_extremum_zero_crossing_detector_top.sv
// testbench for the extremum and zero crossing detector top level
`timescale 1ns / 100ps

module tb_extremum_zero_crossing_detector_top;
  import ezcd_pkg::*;

  localparam int unsigned BUF_LIMIT   = 65536;
  localparam int unsigned RAND_ITEMS  = 90;
  localparam int unsigned QUIET_ITEMS = 50;

  // one expected result item
  typedef struct {
    kind_e              kind;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   n_max;
    logic [CNT_W-1:0]   n_min;
    logic [CNT_W-1:0]   n_zero;
    logic               imf;
    logic               ovf;
    logic               fin;
  } det_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_i    = '0;
  logic               last_i      = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [POS_W-1:0]   position_o;
  logic [CNT_W-1:0]   count_max_o;
  logic [CNT_W-1:0]   count_min_o;
  logic [CNT_W-1:0]   count_zero_o;
  logic               imf_ok_o;
  logic               overflow_o;
  logic               final_res_o;

  // shadow copy of the detector state
  logic signed [15:0] prv_smp;
  dir_e               prv_dir;
  int unsigned        smp_cnt;
  bit                 flat_run;
  int unsigned        flat_start;
  dir_e               flat_entry;
  logic [CNT_W-1:0]   n_max;
  logic [CNT_W-1:0]   n_min;
  logic [CNT_W-1:0]   n_zero;
  bit                 ovf_seen;

  det_result_t pending_detections[$];
  int          err_cnt           = 0;
  bit          src_idle_en       = 1'b1;
  bit          sink_idle_en      = 1'b1;
  int          sink_hold_cycles  = 0;

  extremum_zero_crossing_detector_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .position_o   (position_o),
    .count_max_o  (count_max_o),
    .count_min_o  (count_min_o),
    .count_zero_o (count_zero_o),
    .imf_ok_o     (imf_ok_o),
    .overflow_o   (overflow_o),
    .final_res_o  (final_res_o)
  );

  always #4 clk_i = ~clk_i;

  // clear the shadow state, as after reset and after each summary
  function automatic void clear_tracking();
    prv_smp    = '0;
    prv_dir    = DIR_NONE;
    smp_cnt    = 0;
    flat_run   = 1'b0;
    flat_start = 0;
    flat_entry = DIR_NONE;
    n_max      = '0;
    n_min      = '0;
    n_zero     = '0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  function automatic void push_event(input kind_e k, input int unsigned pos);
    det_result_t r;
    r.kind   = k;
    r.pos    = pos[POS_W-1:0];
    r.n_max  = '0;
    r.n_min  = '0;
    r.n_zero = '0;
    r.imf    = 1'b0;
    r.ovf    = 1'b0;
    r.fin    = 1'b0;
    pending_detections.push_back(r);
  endfunction

  // work out the results of one accepted sample
  function automatic void classify_sample(input logic signed [15:0] x, input logic lst);
    dir_e        d;
    int unsigned idx;
    int unsigned ext_sum;
    int unsigned zc;
    det_result_t s;
    if (smp_cnt >= BUF_LIMIT) begin
      ovf_seen = 1'b1;
    end else begin
      idx = smp_cnt;
      if (idx > 0) begin
        if (x > prv_smp) d = DIR_UP;
        else if (x < prv_smp) d = DIR_DN;
        else d = DIR_FLAT;
        // sign change between neighbors, reported at the earlier one
        if ((prv_smp < 0 && x > 0) || (prv_smp > 0 && x < 0)) begin
          push_event(KIND_ZERO, idx - 1);
          n_zero = sat_inc(n_zero);
        end
        if (d != DIR_FLAT) begin
          if (prv_dir == DIR_UP && d == DIR_DN) begin
            push_event(KIND_MAX, idx - 1);
            n_max = sat_inc(n_max);
          end else if (prv_dir == DIR_DN && d == DIR_UP) begin
            push_event(KIND_MIN, idx - 1);
            n_min = sat_inc(n_min);
          end else if (flat_run) begin
            // plateau extremum at the upward-rounded middle
            if (flat_entry == DIR_UP && d == DIR_DN) begin
              push_event(KIND_MAX, (flat_start + idx) >> 1);
              n_max = sat_inc(n_max);
            end else if (flat_entry == DIR_DN && d == DIR_UP) begin
              push_event(KIND_MIN, (flat_start + idx) >> 1);
              n_min = sat_inc(n_min);
            end
          end
          flat_run = 1'b0;
        end else if (!flat_run) begin
          flat_run   = 1'b1;
          flat_start = idx - 1;
          flat_entry = (prv_dir == DIR_FLAT) ? DIR_NONE : prv_dir;
        end
        prv_dir = d;
      end
      if (x == 0) begin
        push_event(KIND_ZERO, idx);
        n_zero = sat_inc(n_zero);
      end
      prv_smp = x;
      smp_cnt = idx + 1;
    end
    // end of buffer summary
    if (lst) begin
      ext_sum  = n_max + n_min;
      zc       = n_zero;
      s.kind   = KIND_SUM;
      s.pos    = '0;
      s.n_max  = n_max;
      s.n_min  = n_min;
      s.n_zero = n_zero;
      s.imf    = ((ext_sum > zc) ? ext_sum - zc : zc - ext_sum) <= 1;
      s.ovf    = ovf_seen;
      s.fin    = 1'b1;
      pending_detections.push_back(s);
      clear_tracking();
    end
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // offer one item and wait until it is taken
  task automatic send_sample(input logic signed [15:0] smp, input logic lst);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    classify_sample(smp, lst);
  endtask

  task automatic send_buffer(input int vals[$]);
    foreach (vals[i]) send_sample(16'(vals[i]), i == vals.size() - 1);
  endtask

  // receiver: random stalls, plus a long hold when asked
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      sink_hold_cycles--;
    end else if (sink_idle_en) begin
      out_ready_i <= ($urandom_range(0, 99) >= 29);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    det_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_detections.size() == 0) begin
        $display("%0t: unexpected result, kind %0d position %0d", $time, kind_o,
                 position_o);
        err_cnt++;
      end else begin
        want = pending_detections.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("position", want.pos, position_o);
        check_field("count_max", want.n_max, count_max_o);
        check_field("count_min", want.n_min, count_min_o);
        check_field("count_zero", want.n_zero, count_zero_o);
        check_field("imf_ok", want.imf, imf_ok_o);
        check_field("overflow", want.ovf, overflow_o);
        check_field("final_res", want.fin, final_res_o);
      end
    end
  end

  // field extremes, plateaus, single-sample buffers
  task automatic test_directed_shapes();
    int shape[$];
    shape = '{0};
    send_buffer(shape);
    shape = '{-32768};
    send_buffer(shape);
    // flat start, sign flips at the extremes, plateaus of both parities, flat end
    shape = '{5, 5, 7, -32768, 32767, 32767, 32767, -1, 0, 0, 3, 3, 3, 4, 1, 1, -2, -2};
    send_buffer(shape);
    // plateau entered falling and left rising
    shape = '{3, 1, 1, 2};
    send_buffer(shape);
  endtask

  // receiver holds off while busy samples keep coming
  task automatic test_output_stall();
    int v;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    sink_hold_cycles = 400;
    for (int i = 0; i < 32; i++) begin
      v = $urandom_range(1, 32767);
      send_sample(16'((i % 2) ? -v : v), (i % 8) == 7);
    end
  endtask

  // random buffers, mostly small values near zero with repeats
  task automatic test_random_buffers();
    int                 sent;
    int                 len;
    logic signed [15:0] cur;
    sent = 0;
    cur  = '0;
    while (sent < RAND_ITEMS) begin
      src_idle_en  = (sent >= QUIET_ITEMS);
      sink_idle_en = (sent >= QUIET_ITEMS);
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: cur = 16'(int'($urandom_range(0, 4)) - 2);
          5, 6:          cur = cur;
          7, 8:          cur = 16'($urandom);
          default:       cur = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
        send_sample(cur, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    clear_tracking();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_shapes();
    test_output_stall();
    test_random_buffers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_extremum_zero_crossing_detector_top: clean");
    end else begin
      $display("tb_extremum_zero_crossing_detector_top: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("%0t: run limit reached, %0d results outstanding", $time,
             pending_detections.size());
    $display("tb_extremum_zero_crossing_detector_top: errors");
    $finish;
  end

endmodule
